// File: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation shared definitions
// Types and constants shared by the sequencer, the modular multiplier and
// the top level.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Modulus value after reset; truncated to the operand width where used.
  localparam logic [31:0] MODULUS_RESET = 32'd19211;

  // Request from the sequencer to the modular multiplier.
  typedef struct packed {
    logic start;
  } mexp_mul_req_t;

  // Status from the modular multiplier back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_sts_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_DONE   = 5'b10000
  } mexp_state_t;

endpackage

// File: design/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base to the power exponent modulo a programmable modulus, with
// one shared bit-serial modular multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One pass of the multiplier reduces the base, then each exponent bit costs
// a squaring and each set bit a further multiply, and every pass of the
// shared multiplier handles one operand bit per cycle. The unit takes one
// word at a time; in_stall is high from acceptance until the result has
// moved into the output register, which holds it while out_stall is high.
// The modulus is to be written through cfg_wr_en and cfg_wr_data only while
// the unit is idle; the user is bound to this, and the unit itself does not
// enforce it. The modulus resets to 19211, and a modulus of zero acts as one.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] out_power_mod,
  input  logic                     cfg_wr_en,
  input  logic [OPERAND_WIDTH-1:0] cfg_wr_data
);

  localparam logic [OPERAND_WIDTH-1:0] OP_ONE = OPERAND_WIDTH'(1);

  logic [OPERAND_WIDTH-1:0] modulus_r;
  logic [OPERAND_WIDTH-1:0] mod_eff;
  logic                     out_valid_r;
  logic [OPERAND_WIDTH-1:0] out_power_mod_r;

  logic                     seq_idle;
  logic                     res_valid;
  logic                     res_take;
  logic [OPERAND_WIDTH-1:0] res_value;
  mexp_pkg::mexp_mul_req_t  mul_req;
  mexp_pkg::mexp_mul_sts_t  mul_sts;
  logic [OPERAND_WIDTH-1:0] mul_x;
  logic [OPERAND_WIDTH-1:0] mul_y;
  logic [OPERAND_WIDTH-1:0] mul_result;
  logic                     in_accept;

  // Modulus register; zero is treated as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MODULUS_RESET[OPERAND_WIDTH-1:0];
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  assign mod_eff   = (modulus_r == '0) ? OP_ONE : modulus_r;
  assign in_stall  = !seq_idle;
  assign in_accept = in_valid && seq_idle;

  // Output register takes a result whenever its slot is free this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_power_mod_r <= res_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_power_mod_r;

  // Exponent sequencer.
  mexp_seq #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .modulus    (mod_eff),
    .start      (in_accept),
    .base       (in_base),
    .exponent   (in_exponent),
    .idle       (seq_idle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_value  (res_value),
    .mul_req    (mul_req),
    .mul_x      (mul_x),
    .mul_y      (mul_y),
    .mul_sts    (mul_sts),
    .mul_result (mul_result)
  );

  // Shared modular multiplier.
  mexp_mulmod #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .op_x    (mul_x),
    .op_y    (mul_y),
    .modulus (mod_eff),
    .sts     (mul_sts),
    .result  (mul_result)
  );

endmodule

// File: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Bit-serial interleaved multiply and reduce: x * y mod m, one bit of x per
// cycle, most significant first. Requires y <= m; x may be any value.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mexp_pkg::mexp_mul_req_t   req,
  input  logic [OPERAND_WIDTH-1:0]  op_x,
  input  logic [OPERAND_WIDTH-1:0]  op_y,
  input  logic [OPERAND_WIDTH-1:0]  modulus,
  output mexp_pkg::mexp_mul_sts_t   sts,
  output logic [OPERAND_WIDTH-1:0]  result
);

  localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [OPERAND_WIDTH-1:0] acc_r;
  logic [OPERAND_WIDTH-1:0] x_r;
  logic [OPERAND_WIDTH-1:0] y_r;

  logic [OPERAND_WIDTH:0]   mod_ext;
  logic [OPERAND_WIDTH:0]   dbl;
  logic [OPERAND_WIDTH:0]   dbl_red;
  logic [OPERAND_WIDTH:0]   sum;
  logic [OPERAND_WIDTH:0]   sum_red;
  logic [OPERAND_WIDTH-1:0] acc_nxt;

  // One step: acc = (2*acc + xbit*y) mod m, each half kept below 2m.
  always_comb begin
    mod_ext = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + (x_r[OPERAND_WIDTH-1] ? {1'b0, y_r} : '0);
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    acc_nxt = sum_red[OPERAND_WIDTH-1:0];
  end

  // Control: a start loads the operands, then one bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(OPERAND_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      x_r   <= {x_r[OPERAND_WIDTH-2:0], 1'b0};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

// File: design/mexp_seq.sv
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Reduces the base, then walks the exponent bits from the top, issuing one
// square per bit and one multiply per set bit to the shared multiplier.
// ----------------------------------------------------------------------------
module mexp_seq #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [OPERAND_WIDTH-1:0]  modulus,
  input  logic                      start,
  input  logic [OPERAND_WIDTH-1:0]  base,
  input  logic [OPERAND_WIDTH-1:0]  exponent,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_take,
  output logic [OPERAND_WIDTH-1:0]  res_value,
  output mexp_pkg::mexp_mul_req_t   mul_req,
  output logic [OPERAND_WIDTH-1:0]  mul_x,
  output logic [OPERAND_WIDTH-1:0]  mul_y,
  input  mexp_pkg::mexp_mul_sts_t   mul_sts,
  input  logic [OPERAND_WIDTH-1:0]  mul_result
);

  localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);
  localparam logic [OPERAND_WIDTH-1:0] OP_ONE = OPERAND_WIDTH'(1);

  mexp_pkg::mexp_state_t    state_r, state_nxt;
  logic                     start_r, start_nxt;
  logic [OPERAND_WIDTH-1:0] x_r, x_nxt;
  logic [OPERAND_WIDTH-1:0] y_r, y_nxt;
  logic [OPERAND_WIDTH-1:0] base_r, base_nxt;
  logic [OPERAND_WIDTH-1:0] acc_r, acc_nxt;
  logic [OPERAND_WIDTH-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic                     last_bit;

  assign last_bit = (bit_cnt_r == CNT_W'(1));

  // Next-state logic for the exponent walk.
  always_comb begin
    state_nxt   = state_r;
    start_nxt   = 1'b0;
    x_nxt       = x_r;
    y_nxt       = y_r;
    base_nxt    = base_r;
    acc_nxt     = acc_r;
    exp_nxt     = exp_r;
    bit_cnt_nxt = bit_cnt_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          // Base mod m is computed as base * 1 mod m.
          x_nxt       = base;
          y_nxt       = OP_ONE;
          start_nxt   = 1'b1;
          exp_nxt     = exponent;
          acc_nxt     = (modulus == OP_ONE) ? '0 : OP_ONE;
          bit_cnt_nxt = CNT_W'(OPERAND_WIDTH);
          state_nxt   = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_sts.done) begin
          base_nxt  = mul_result;
          x_nxt     = acc_r;
          y_nxt     = acc_r;
          start_nxt = 1'b1;
          state_nxt = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_sts.done) begin
          acc_nxt = mul_result;
          if (exp_r[OPERAND_WIDTH-1]) begin
            x_nxt     = mul_result;
            y_nxt     = base_r;
            start_nxt = 1'b1;
            state_nxt = mexp_pkg::ST_MULT;
          end else begin
            exp_nxt     = {exp_r[OPERAND_WIDTH-2:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
            if (last_bit) begin
              state_nxt = mexp_pkg::ST_DONE;
            end else begin
              x_nxt     = mul_result;
              y_nxt     = mul_result;
              start_nxt = 1'b1;
            end
          end
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mul_sts.done) begin
          acc_nxt     = mul_result;
          exp_nxt     = {exp_r[OPERAND_WIDTH-2:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
          if (last_bit) begin
            state_nxt = mexp_pkg::ST_DONE;
          end else begin
            x_nxt     = mul_result;
            y_nxt     = mul_result;
            start_nxt = 1'b1;
            state_nxt = mexp_pkg::ST_SQUARE;
          end
        end
      end
      mexp_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    exp_r     <= exp_nxt;
    bit_cnt_r <= bit_cnt_nxt;
  end

  assign idle          = (state_r == mexp_pkg::ST_IDLE);
  assign res_valid     = (state_r == mexp_pkg::ST_DONE);
  assign res_value     = acc_r;
  assign mul_req.start = start_r;
  assign mul_x         = x_r;
  assign mul_y         = y_r;

endmodule
